>>> rtl/cdn_pkg.sv
// Package for the calendar date day number unit.
// Holds the shared step unit control type, its operation codes and the
// calendar helper functions. Depends on nothing.
package cdn_pkg;

    localparam int unsigned AccW = 19;

    localparam logic [1:0] OP_HOLD = 2'd0;
    localparam logic [1:0] OP_LOAD = 2'd1;
    localparam logic [1:0] OP_ADD  = 2'd2;
    localparam logic [1:0] OP_SUB  = 2'd3;

    localparam logic [11:0] FIRST_YEAR    = 12'd1900;
    localparam logic [11:0] LAST_YEAR     = 12'd2099;
    localparam logic [7:0]  LAST_YEAR_IDX = 8'd199;
    localparam logic [7:0]  FALLBACK_IDX  = 8'd100;
    localparam logic [16:0] LAST_SERIAL   = 17'd73049;

    typedef logic signed [AccW-1:0] acc_t;

    typedef struct packed {
        logic [1:0] op;
        acc_t       operand;
    } step_ctl_t;

    // Years are held as an index from 1900; in 1900..2099 only 1900 breaks
    // the every-fourth-year rule.
    function automatic logic is_leap(input logic [7:0] yi);
        is_leap = (yi[1:0] == 2'd0) && (yi != 8'd0);
    endfunction

    function automatic logic [8:0] year_days(input logic [7:0] yi);
        year_days = is_leap(yi) ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [4:0] month_days(input logic [7:0] yi, input logic [3:0] m);
        case (m)
            4'd2:                       month_days = is_leap(yi) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    month_days = 5'd30;
            default:                    month_days = 5'd31;
        endcase
    endfunction

endpackage

>>> rtl/cdn_step_unit.sv
// Shared add, subtract and compare unit with its accumulator.
// Uses cdn_pkg for the control type and operation codes.
module cdn_step_unit
(
    input  logic              clk,
    input  cdn_pkg::step_ctl_t ctl,
    output cdn_pkg::acc_t     acc,
    output logic              le
);

    cdn_pkg::acc_t acc_reg;
    cdn_pkg::acc_t acc_next;

    always_comb
    begin
        case (ctl.op)
            cdn_pkg::OP_LOAD: acc_next = ctl.operand;
            cdn_pkg::OP_ADD:  acc_next = acc_reg + ctl.operand;
            cdn_pkg::OP_SUB:  acc_next = acc_reg - ctl.operand;
            default:          acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;
    assign le  = (acc_reg <= ctl.operand);

endmodule

>>> rtl/calendar_date_day_number_unit.sv
// Top level of the calendar date day number unit: sequencer and output register.
// Uses cdn_pkg and one cdn_step_unit for all day arithmetic.
//
// Channel  Handshake             Payload
// input    in_valid / in_stall   action, in_year, in_month, in_day, offset
// output   out_valid / out_stall out_year, out_month, out_day, day_number, clamped
//
// One request is worked at a time by a single adder that walks year by year and
// then month by month. Action 1 goes straight to the clamp and the walk back to a
// date; action 0 first adds the day number of the input date, counted from 1900.
// A new request is taken while a finished result still waits under out_stall.
// Reset is asynchronous and leaves the unit idle with no result pending.
module calendar_date_day_number_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic [11:0]        in_year,
    input  logic [3:0]         in_month,
    input  logic [4:0]         in_day,
    input  logic signed [17:0] offset,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [11:0]        out_year,
    output logic [3:0]         out_month,
    output logic [4:0]         out_day,
    output logic [16:0]        day_number,
    output logic               clamped
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DAY    = 4'd1;
    localparam logic [3:0] S_YEARS  = 4'd2;
    localparam logic [3:0] S_MONTHS = 4'd3;
    localparam logic [3:0] S_CLAMP  = 4'd4;
    localparam logic [3:0] S_YWALK  = 4'd5;
    localparam logic [3:0] S_MWALK  = 4'd6;
    localparam logic [3:0] S_DONE   = 4'd7;

    logic [3:0]  state_reg, state_next;
    logic [7:0]  yi_reg, yi_next;
    logic [3:0]  mon_reg, mon_next;
    logic [4:0]  day_reg, day_next;
    logic [7:0]  yc_reg, yc_next;
    logic [3:0]  mc_reg, mc_next;
    logic [16:0] sn_reg, sn_next;
    logic        clamp_reg, clamp_next;
    logic        out_valid_reg, out_valid_next;
    logic [11:0] out_year_reg, out_year_next;
    logic [3:0]  out_month_reg, out_month_next;
    logic [4:0]  out_day_reg, out_day_next;
    logic [16:0] day_number_reg, day_number_next;
    logic        clamped_reg, clamped_next;

    cdn_pkg::step_ctl_t ctl;
    cdn_pkg::acc_t      acc;
    logic               le;

    logic [7:0]  yi_in;
    logic [3:0]  mon_in;
    logic        year_ok;
    logic [11:0] year_off;
    logic [4:0]  year_len_pad;
    logic        low_clip;
    logic        high_clip;

    cdn_step_unit u_step
    (
        .clk (clk),
        .ctl (ctl),
        .acc (acc),
        .le  (le)
    );

    assign year_ok  = (in_year >= cdn_pkg::FIRST_YEAR) && (in_year <= cdn_pkg::LAST_YEAR);
    assign year_off = in_year - cdn_pkg::FIRST_YEAR;
    assign yi_in    = year_ok ? year_off[7:0] : cdn_pkg::FALLBACK_IDX;
    assign mon_in   = ((in_month >= 4'd1) && (in_month <= 4'd12)) ? in_month : 4'd1;

    assign low_clip  = acc[cdn_pkg::AccW-1] || (acc == '0);
    assign high_clip = acc > $signed({2'b00, cdn_pkg::LAST_SERIAL});
    assign year_len_pad = 5'd0;

    always_comb
    begin
        state_next      = state_reg;
        yi_next         = yi_reg;
        mon_next        = mon_reg;
        day_next        = day_reg;
        yc_next         = yc_reg;
        mc_next         = mc_reg;
        sn_next         = sn_reg;
        clamp_next      = clamp_reg;
        out_year_next   = out_year_reg;
        out_month_next  = out_month_reg;
        out_day_next    = out_day_reg;
        day_number_next = day_number_reg;
        clamped_next    = clamped_reg;
        out_valid_next  = out_valid_reg && out_stall;
        ctl.op          = cdn_pkg::OP_HOLD;
        ctl.operand     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.op      = cdn_pkg::OP_LOAD;
                    ctl.operand = {offset[17], offset};
                    yi_next     = yi_in;
                    mon_next    = mon_in;
                    day_next    = ((in_day >= 5'd1) &&
                                   (in_day <= cdn_pkg::month_days(yi_in, mon_in))) ?
                                  in_day : 5'd1;
                    yc_next     = 8'd0;
                    mc_next     = 4'd1;
                    state_next  = action ? S_CLAMP : S_DAY;
                end
            end
            S_DAY:
            begin
                ctl.op      = cdn_pkg::OP_ADD;
                ctl.operand = {14'd0, day_reg};
                state_next  = S_YEARS;
            end
            S_YEARS:
            begin
                if (yc_reg == yi_reg)
                begin
                    state_next = S_MONTHS;
                end
                else
                begin
                    ctl.op      = cdn_pkg::OP_ADD;
                    ctl.operand = {year_len_pad, 5'd0, cdn_pkg::year_days(yc_reg)};
                    yc_next     = yc_reg + 8'd1;
                end
            end
            S_MONTHS:
            begin
                if (mc_reg == mon_reg)
                begin
                    state_next = S_CLAMP;
                end
                else
                begin
                    ctl.op      = cdn_pkg::OP_ADD;
                    ctl.operand = {14'd0, cdn_pkg::month_days(yi_reg, mc_reg)};
                    mc_next     = mc_reg + 4'd1;
                end
            end
            S_CLAMP:
            begin
                yc_next    = 8'd0;
                mc_next    = 4'd1;
                state_next = S_YWALK;
                if (low_clip)
                begin
                    ctl.op      = cdn_pkg::OP_LOAD;
                    ctl.operand = 19'sd1;
                    sn_next     = 17'd1;
                    clamp_next  = 1'b1;
                end
                else if (high_clip)
                begin
                    ctl.op      = cdn_pkg::OP_LOAD;
                    ctl.operand = $signed({2'b00, cdn_pkg::LAST_SERIAL});
                    sn_next     = cdn_pkg::LAST_SERIAL;
                    clamp_next  = 1'b1;
                end
                else
                begin
                    sn_next    = acc[16:0];
                    clamp_next = 1'b0;
                end
            end
            S_YWALK:
            begin
                ctl.operand = {year_len_pad, 5'd0, cdn_pkg::year_days(yc_reg)};
                if (le || (yc_reg == cdn_pkg::LAST_YEAR_IDX))
                begin
                    state_next = S_MWALK;
                end
                else
                begin
                    ctl.op  = cdn_pkg::OP_SUB;
                    yc_next = yc_reg + 8'd1;
                end
            end
            S_MWALK:
            begin
                ctl.operand = {14'd0, cdn_pkg::month_days(yc_reg, mc_reg)};
                if (le || (mc_reg == 4'd12))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ctl.op  = cdn_pkg::OP_SUB;
                    mc_next = mc_reg + 4'd1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_year_next   = cdn_pkg::FIRST_YEAR + {4'd0, yc_reg};
                    out_month_next  = mc_reg;
                    out_day_next    = acc[4:0];
                    day_number_next = sn_reg;
                    clamped_next    = clamp_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        yi_reg         <= yi_next;
        mon_reg        <= mon_next;
        day_reg        <= day_next;
        yc_reg         <= yc_next;
        mc_reg         <= mc_next;
        sn_reg         <= sn_next;
        clamp_reg      <= clamp_next;
        out_year_reg   <= out_year_next;
        out_month_reg  <= out_month_next;
        out_day_reg    <= out_day_next;
        day_number_reg <= day_number_next;
        clamped_reg    <= clamped_next;
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_year   = out_year_reg;
    assign out_month  = out_month_reg;
    assign out_day    = out_day_reg;
    assign day_number = day_number_reg;
    assign clamped    = clamped_reg;

`ifndef SYNTHESIS
    a_serial_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (day_number >= 17'd1) && (day_number <= cdn_pkg::LAST_SERIAL))
        else $error("result day number out of range");

    a_date_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_month >= 4'd1) && (out_month <= 4'd12) && (out_day >= 5'd1))
        else $error("result date fields out of range");

    a_year_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_YWALK) |-> (yc_reg <= cdn_pkg::LAST_YEAR_IDX))
        else $error("year walk ran past the last year");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != S_IDLE))
        else $error("accepted request did not start the sequencer");
`endif

endmodule
